// ===== sv/pit_pkg.sv =====
// ----------------------------------------------------------------------------
// pit_pkg
// widths and shared types for the point-in-triangle test pipeline
// ----------------------------------------------------------------------------
package pit_pkg;

   // coordinate width of every input field
   localparam int CoordW = 16;
   // vertex-relative difference, one bit of growth
   localparam int DiffW  = CoordW + 1;
   // product of two differences
   localparam int ProdW  = 2 * DiffW;
   // difference of two products (determinant, numerators)
   localparam int CrossW = ProdW + 1;
   // d - nb - nc needs two more bits of headroom
   localparam int NumAW  = CrossW + 2;

   typedef logic signed [CoordW-1:0] coord_type;
   typedef logic signed [DiffW-1:0]  diff_type;
   typedef logic signed [ProdW-1:0]  prod_type;
   typedef logic signed [CrossW-1:0] cross_type;
   typedef logic signed [NumAW-1:0]  num_a_type;

   // pipeline advance enables handed to the cross-product unit
   typedef struct packed {
      logic adv_prod;
      logic adv_diff;
   } pit_adv_type;

   // numerator sign test: zero or same sign as the determinant
   function automatic logic agrees(input logic n_zero, input logic n_neg,
                                   input logic d_neg);
      agrees = n_zero || (n_neg == d_neg);
   endfunction

endpackage

// ===== sv/pit_ifs.sv =====
// ----------------------------------------------------------------------------
// pit channel interfaces
// valid/ready channels for triangle requests and inside/outside responses
// ----------------------------------------------------------------------------
interface pit_req_if;
   logic              valid;
   logic              ready;
   pit_pkg::coord_type a_x;
   pit_pkg::coord_type a_y;
   pit_pkg::coord_type b_x;
   pit_pkg::coord_type b_y;
   pit_pkg::coord_type c_x;
   pit_pkg::coord_type c_y;
   pit_pkg::coord_type p_x;
   pit_pkg::coord_type p_y;

   modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y,
                   input ready);
   modport sink   (input valid, a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y,
                   output ready);
endinterface

interface pit_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, inside_res, input ready);
   modport sink   (input valid, inside_res, output ready);
endinterface

// ===== sv/pit_cross.sv =====
// ----------------------------------------------------------------------------
// pit_cross
// two-stage 2d cross product: u_x*v_y - v_x*u_y, products registered first
// ----------------------------------------------------------------------------
module pit_cross (
   input  logic                clock,
   input  pit_pkg::pit_adv_type adv,
   input  pit_pkg::diff_type   u_x,
   input  pit_pkg::diff_type   u_y,
   input  pit_pkg::diff_type   v_x,
   input  pit_pkg::diff_type   v_y,
   output pit_pkg::cross_type  cross_out
);

   pit_pkg::prod_type  lhs_in, lhs_ff;
   pit_pkg::prod_type  rhs_in, rhs_ff;
   pit_pkg::cross_type cross_in, cross_ff;

   assign lhs_in   = u_x * v_y;
   assign rhs_in   = v_x * u_y;
   assign cross_in = pit_pkg::CrossW'(lhs_ff) - pit_pkg::CrossW'(rhs_ff);

   always_ff @(posedge clock) begin
      if (adv.adv_prod) begin
         lhs_ff <= lhs_in;
         rhs_ff <= rhs_in;
      end
      if (adv.adv_diff) begin
         cross_ff <= cross_in;
      end
   end

   assign cross_out = cross_ff;

endmodule

// ===== sv/point_in_triangle_test.sv =====
// throughput: one beat per cycle, no bubbles while the response side is ready
// a request beat passes four pipeline registers on its way to the response:
// differences, products, cross differences, and the sign test feeding the
// response register
// reset: synchronous, clears all stage valid bits; payload registers hold
// ----------------------------------------------------------------------------
// point_in_triangle_test
// exact integer barycentric inside test of a point against a triangle,
// edges and vertices inside, degenerate triangles without a vertex hit outside
// ----------------------------------------------------------------------------
module point_in_triangle_test (
   input logic   clock,
   input logic   reset,
   pit_req_if.sink   req_if,
   pit_rsp_if.source rsp_if
);

   // stage valid bits and per-stage advance enables
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic en1, en2, en3, en4;

   // stage 1: vertex match and origin moved to vertex a
   logic              vtx1_ff, vtx1_in;
   pit_pkg::diff_type rbx_ff, rby_ff, rcx_ff, rcy_ff, rpx_ff, rpy_ff;

   // stages 2 and 3: vertex flag riding alongside the cross products
   logic vtx2_ff, vtx3_ff;

   // stage 3 outputs of the cross units
   pit_pkg::cross_type  det, num_b, num_c;
   pit_pkg::num_a_type  num_a;
   pit_pkg::pit_adv_type adv;

   // stage 4: response register
   logic inside_ff, inside_in;
   logic det_zero, det_neg;

   // each stage moves when it is empty or its successor moves
   assign en4 = !v4_ff || rsp_if.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_if.ready = en1;

   assign v1_in = en1 ? req_if.valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;
   assign v4_in = en4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // a point sitting on any vertex is inside, even for a degenerate triangle
   assign vtx1_in = (req_if.a_x == req_if.p_x && req_if.a_y == req_if.p_y) ||
                    (req_if.b_x == req_if.p_x && req_if.b_y == req_if.p_y) ||
                    (req_if.c_x == req_if.p_x && req_if.c_y == req_if.p_y);

   always_ff @(posedge clock) begin
      if (en1) begin
         vtx1_ff <= vtx1_in;
         rbx_ff  <= pit_pkg::DiffW'(req_if.b_x) - pit_pkg::DiffW'(req_if.a_x);
         rby_ff  <= pit_pkg::DiffW'(req_if.b_y) - pit_pkg::DiffW'(req_if.a_y);
         rcx_ff  <= pit_pkg::DiffW'(req_if.c_x) - pit_pkg::DiffW'(req_if.a_x);
         rcy_ff  <= pit_pkg::DiffW'(req_if.c_y) - pit_pkg::DiffW'(req_if.a_y);
         rpx_ff  <= pit_pkg::DiffW'(req_if.p_x) - pit_pkg::DiffW'(req_if.a_x);
         rpy_ff  <= pit_pkg::DiffW'(req_if.p_y) - pit_pkg::DiffW'(req_if.a_y);
      end
      if (en2) begin
         vtx2_ff <= vtx1_ff;
      end
      if (en3) begin
         vtx3_ff <= vtx2_ff;
      end
   end

   // products land in stage 2, their differences in stage 3
   assign adv.adv_prod = en2;
   assign adv.adv_diff = en3;

   // determinant d = rb x rc
   pit_cross u_det (
      .clock     (clock),
      .adv       (adv),
      .u_x       (rbx_ff),
      .u_y       (rby_ff),
      .v_x       (rcx_ff),
      .v_y       (rcy_ff),
      .cross_out (det)
   );

   // numerator for b: rp x rc
   pit_cross u_num_b (
      .clock     (clock),
      .adv       (adv),
      .u_x       (rpx_ff),
      .u_y       (rpy_ff),
      .v_x       (rcx_ff),
      .v_y       (rcy_ff),
      .cross_out (num_b)
   );

   // numerator for c: rb x rp
   pit_cross u_num_c (
      .clock     (clock),
      .adv       (adv),
      .u_x       (rbx_ff),
      .u_y       (rby_ff),
      .v_x       (rpx_ff),
      .v_y       (rpy_ff),
      .cross_out (num_c)
   );

   // the three numerators sum to d; each must be zero or share its sign
   assign num_a    = pit_pkg::NumAW'(det) - pit_pkg::NumAW'(num_b)
                     - pit_pkg::NumAW'(num_c);
   assign det_zero = (det == '0);
   assign det_neg  = det[pit_pkg::CrossW-1];

   assign inside_in = vtx3_ff ||
                      (!det_zero &&
                       pit_pkg::agrees(num_a == '0, num_a[pit_pkg::NumAW-1], det_neg) &&
                       pit_pkg::agrees(num_b == '0, num_b[pit_pkg::CrossW-1], det_neg) &&
                       pit_pkg::agrees(num_c == '0, num_c[pit_pkg::CrossW-1], det_neg));

   always_ff @(posedge clock) begin
      if (en4) begin
         inside_ff <= inside_in;
      end
   end

   assign rsp_if.valid      = v4_ff;
   assign rsp_if.inside_res = inside_ff;

   // an accepted request beat always occupies the first stage next cycle
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> v1_ff)
      else $error("accepted beat did not enter stage 1");

   // a vertex hit reaching the response register reports inside
   a_vertex_inside: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && en4 && vtx3_ff) |=> (v4_ff && rsp_if.inside_res))
      else $error("vertex hit not reported inside");

   // a degenerate triangle without a vertex hit reports outside
   a_degenerate_outside: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && en4 && !vtx3_ff && det_zero) |=> (v4_ff && !rsp_if.inside_res))
      else $error("degenerate triangle not reported outside");

   // a stalled middle stage keeps its vertex flag
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !en2) |=> (v2_ff && $stable(vtx2_ff)))
      else $error("stalled stage 2 lost its contents");

endmodule
